// ===== rtl/msp_pkg.sv =====
// Shared package for the minimum square-sum partition core.
// Holds default sizes, the controller state type and the command/status bundles.
// No dependencies.
`timescale 1ns / 1ps

package msp_pkg;

  localparam int MaxLenDef    = 4096;
  localparam int ValueBitsDef = 16;
  localparam int DataBits     = 16;
  localparam int GroupBits    = 13;
  localparam int CostBits     = 56;
  localparam int SqBits       = 28;
  localparam int AddrBits     = 3;

  // Register byte addresses.
  localparam logic [AddrBits-1:0] RegGroupCount = 3'd0;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_LCHK,
    ST_LSTART,
    ST_POP,
    ST_CHECK,
    ST_MID,
    ST_SCAN,
    ST_WRITE,
    ST_LEND,
    ST_FRD,
    ST_FWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic init_step;
    logic layer_start;
    logic pop;
    logic check;
    logic mid_cap;
    logic scan_issue;
    logic write_node;
    logic layer_end;
    logic final_rd;
    logic final_cap;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic layers_done;
    logic stack_empty;
    logic range_empty;
    logic issue_done;
    logic pipe_empty;
    logic stack_room;
  } stat_t;

endpackage

// ===== rtl/msp_ctrl.sv =====
// Sequencing controller for the minimum square-sum partition core.
// Drives datapath commands from datapath status; uses msp_pkg.
`timescale 1ns / 1ps

module msp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  input  logic          out_free,
  input  msp_pkg::stat_t stat,
  output msp_pkg::cmd_t  cmd,
  output logic          in_ready
);

  msp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msp_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      msp_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) state_next = msp_pkg::ST_INIT;
      end
      msp_pkg::ST_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_done) state_next = msp_pkg::ST_LCHK;
      end
      msp_pkg::ST_LCHK: begin
        state_next = stat.layers_done ? msp_pkg::ST_FRD : msp_pkg::ST_LSTART;
      end
      msp_pkg::ST_LSTART: begin
        cmd.layer_start = 1'b1;
        state_next      = msp_pkg::ST_POP;
      end
      msp_pkg::ST_POP: begin
        if (stat.stack_empty) begin
          state_next = msp_pkg::ST_LEND;
        end else begin
          cmd.pop    = 1'b1;
          state_next = msp_pkg::ST_CHECK;
        end
      end
      msp_pkg::ST_CHECK: begin
        if (stat.range_empty) begin
          state_next = msp_pkg::ST_POP;
        end else begin
          cmd.check  = 1'b1;
          state_next = msp_pkg::ST_MID;
        end
      end
      msp_pkg::ST_MID: begin
        cmd.mid_cap = 1'b1;
        state_next  = msp_pkg::ST_SCAN;
      end
      msp_pkg::ST_SCAN: begin
        cmd.scan_issue = !stat.issue_done;
        if (stat.issue_done && stat.pipe_empty) state_next = msp_pkg::ST_WRITE;
      end
      msp_pkg::ST_WRITE: begin
        cmd.write_node = 1'b1;
        state_next     = msp_pkg::ST_POP;
      end
      msp_pkg::ST_LEND: begin
        cmd.layer_end = 1'b1;
        state_next    = msp_pkg::ST_LCHK;
      end
      msp_pkg::ST_FRD: begin
        cmd.final_rd = 1'b1;
        state_next   = msp_pkg::ST_FWAIT;
      end
      msp_pkg::ST_FWAIT: begin
        cmd.final_cap = 1'b1;
        state_next    = msp_pkg::ST_OUT;
      end
      msp_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.deliver = 1'b1;
          state_next  = msp_pkg::ST_LOAD;
        end
      end
      default: state_next = msp_pkg::ST_LOAD;
    endcase
  end

endmodule

// ===== rtl/msp_datapath.sv =====
// Datapath of the minimum square-sum partition core: prefix memory, two DP row
// memories, the range stack and the split evaluation pipeline. Uses msp_pkg.
`timescale 1ns / 1ps

module msp_datapath #(
  parameter int MAX_LEN    = msp_pkg::MaxLenDef,
  parameter int VALUE_BITS = msp_pkg::ValueBitsDef
) (
  input  logic                            clk,
  input  logic                            rst,
  input  msp_pkg::cmd_t                   cmd,
  input  logic [msp_pkg::DataBits-1:0]    in_value,
  input  logic [msp_pkg::GroupBits-1:0]   group_count,
  output msp_pkg::stat_t                  stat,
  output logic [msp_pkg::CostBits-1:0]    res_cost,
  output logic                            res_trunc
);

  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int XW  = CW + 1;
  localparam int PW  = VALUE_BITS + $clog2(MAX_LEN);
  localparam int LW  = (CW > msp_pkg::GroupBits) ? CW : msp_pkg::GroupBits;
  localparam int SD  = CW + 4;
  localparam int SIW = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);
  localparam int CB  = msp_pkg::CostBits;
  localparam int RW  = CB + 1;
  localparam int SQ  = msp_pkg::SqBits;
  localparam logic [CB-1:0] CostMax = {CB{1'b1}};
  localparam logic [msp_pkg::DataBits-1:0] VMask =
    msp_pkg::DataBits'((64'd1 << VALUE_BITS) - 64'd1);

  // Load and sweep state.
  logic [CW-1:0] cnt;
  logic [PW-1:0] sum;
  logic          dropped;
  logic [CW-1:0] init_i;
  logic          sel;
  logic [LW-1:0] layer;
  logic [LW-1:0] lim;

  // Range stack.
  logic [SPW-1:0] sp;
  logic [CW-1:0]  stk_lo [SD];
  logic [CW-1:0]  stk_hi [SD];
  logic [CW-1:0]  stk_olo [SD];
  logic [CW-1:0]  stk_ohi [SD];
  logic [CW-1:0]  r_lo, r_hi, r_olo, r_ohi;

  // Node evaluation.
  logic [CW-1:0] mid, xend, mid_c, opt;
  logic [XW-1:0] x;
  logic [CW-1:0] xm1;
  logic [PW-1:0] pmid;
  logic [CB-1:0] best;
  logic          found;

  // Memories.
  logic [PW-1:0] pre_mem [MAX_LEN+1];
  logic [RW-1:0] row_a [MAX_LEN+1];
  logic [RW-1:0] row_b [MAX_LEN+1];
  logic [PW-1:0] pa_rd, pb_rd;
  logic [RW-1:0] ra_rd, rb_rd, prev_rd;

  logic          pre_we;
  logic [CW-1:0] pre_wa;
  logic [PW-1:0] pre_wd;
  logic [PW-1:0] v_ext;
  logic          a_we, b_we;
  logic [CW-1:0] a_wa, b_wa, row_ra;
  logic [RW-1:0] a_wd, b_wd, node_wd;

  // Pipeline.
  logic          v1, v2, v3, v4;
  logic [CW-1:0] x1, x2, x3, x4;
  logic [PW-1:0] d2;
  logic [CB-1:0] pv2, pv3, sq3, cs4;
  logic          ok2, ok3, ok4;
  logic [SQ-1:0] dl;
  logic [2*SQ-1:0] prod;
  logic [RW-1:0] sum57;

  logic push_r, push_l;

  assign v_ext   = PW'(in_value & VMask);
  assign mid_c   = CW'((XW'(r_lo) + XW'(r_hi)) >> 1);
  assign xm1     = CW'(x - XW'(1));
  assign row_ra  = cmd.final_rd ? cnt : xm1;
  assign prev_rd = sel ? rb_rd : ra_rd;
  assign lim     = (LW'(group_count) < LW'(cnt)) ? LW'(group_count) : LW'(cnt);
  assign node_wd = {found, found ? best : {CB{1'b0}}};
  assign push_r  = mid < r_hi;
  assign push_l  = mid > r_lo;

  assign stat.init_done   = init_i == cnt;
  assign stat.layers_done = layer == lim;
  assign stat.stack_empty = sp == '0;
  assign stat.range_empty = r_lo > r_hi;
  assign stat.issue_done  = x > XW'(xend);
  assign stat.pipe_empty  = !(v1 || v2 || v3 || v4);
  assign stat.stack_room  = ({1'b0, sp} + (SPW+1)'(2)) <= (SPW+1)'(SD);

  // Write port selection.
  always_comb begin
    pre_we = 1'b0;
    pre_wa = '0;
    pre_wd = '0;
    if (cmd.load) begin
      pre_we = cnt != CW'(MAX_LEN);
      pre_wa = cnt + CW'(1);
      pre_wd = sum + v_ext;
    end else if (cmd.init_step && init_i == '0) begin
      pre_we = 1'b1;
    end
  end

  always_comb begin
    a_we = 1'b0;
    a_wa = init_i;
    a_wd = {init_i == '0, {CB{1'b0}}};
    b_we = 1'b0;
    b_wa = '0;
    b_wd = {1'b1, {CB{1'b0}}};
    if (cmd.init_step) begin
      a_we = 1'b1;
      b_we = init_i == '0;
    end else if (cmd.write_node) begin
      a_we = sel;
      a_wa = mid;
      a_wd = node_wd;
      b_we = !sel;
      b_wa = mid;
      b_wd = node_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (pre_we) pre_mem[pre_wa] <= pre_wd;
    pa_rd <= pre_mem[mid_c];
    pb_rd <= pre_mem[xm1];
  end

  always_ff @(posedge clk) begin
    if (a_we) row_a[a_wa] <= a_wd;
    ra_rd <= row_a[row_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) row_b[b_wa] <= b_wd;
    rb_rd <= row_b[row_ra];
  end

  // Squared difference with saturation above the square limit.
  assign dl   = SQ'(d2);
  assign prod = dl * dl;
  assign sum57 = RW'(pv3) + RW'(sq3);

  always_ff @(posedge clk) begin
    x1  <= CW'(x);
    d2  <= pmid - pb_rd;
    pv2 <= prev_rd[CB-1:0];
    ok2 <= prev_rd[CB];
    x2  <= x1;
    sq3 <= ((d2 >> SQ) != '0) ? CostMax : CB'(prod);
    pv3 <= pv2;
    ok3 <= ok2;
    x3  <= x2;
    cs4 <= sum57[CB] ? CostMax : sum57[CB-1:0];
    ok4 <= ok3;
    x4  <= x3;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.scan_issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Node search state.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.check) begin
      found <= 1'b0;
      opt   <= r_olo;
      x     <= XW'(r_olo);
      mid   <= mid_c;
      xend  <= (mid_c < r_ohi) ? mid_c : r_ohi;
    end else begin
      if (cmd.scan_issue) x <= x + XW'(1);
      if (cmd.mid_cap) pmid <= pa_rd;
      if (v4 && ok4 && (!found || cs4 < best)) begin
        best  <= cs4;
        opt   <= x4;
        found <= 1'b1;
      end
    end
  end

  // Range stack.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.layer_start) begin
      stk_lo[0]  <= CW'(1);
      stk_hi[0]  <= cnt;
      stk_olo[0] <= CW'(1);
      stk_ohi[0] <= cnt;
      sp         <= SPW'(1);
    end else if (cmd.pop) begin
      r_lo  <= stk_lo[SIW'(sp - SPW'(1))];
      r_hi  <= stk_hi[SIW'(sp - SPW'(1))];
      r_olo <= stk_olo[SIW'(sp - SPW'(1))];
      r_ohi <= stk_ohi[SIW'(sp - SPW'(1))];
      sp    <= sp - SPW'(1);
    end else if (cmd.write_node && stat.stack_room) begin
      if (push_r) begin
        stk_lo[SIW'(sp)]  <= mid + CW'(1);
        stk_hi[SIW'(sp)]  <= r_hi;
        stk_olo[SIW'(sp)] <= opt;
        stk_ohi[SIW'(sp)] <= r_ohi;
      end
      if (push_l) begin
        stk_lo[SIW'(sp + SPW'(push_r))]  <= r_lo;
        stk_hi[SIW'(sp + SPW'(push_r))]  <= mid - CW'(1);
        stk_olo[SIW'(sp + SPW'(push_r))] <= r_olo;
        stk_ohi[SIW'(sp + SPW'(push_r))] <= opt;
      end
      sp <= sp + SPW'(push_r) + SPW'(push_l);
    end
  end

  // Loading, sweep and layer bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      sum     <= '0;
      dropped <= 1'b0;
      init_i  <= '0;
      sel     <= 1'b0;
      layer   <= '0;
    end else begin
      if (cmd.load) begin
        if (cnt != CW'(MAX_LEN)) begin
          cnt <= cnt + CW'(1);
          sum <= sum + v_ext;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.init_step) begin
        if (stat.init_done) begin
          init_i <= '0;
          sel    <= 1'b0;
          layer  <= '0;
        end else begin
          init_i <= init_i + CW'(1);
        end
      end
      if (cmd.layer_end) begin
        sel   <= !sel;
        layer <= layer + LW'(1);
      end
      if (cmd.deliver) begin
        cnt     <= '0;
        sum     <= '0;
        dropped <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.final_cap) begin
      res_cost  <= prev_rd[CB] ? prev_rd[CB-1:0] : CostMax;
      res_trunc <= dropped;
    end
  end

endmodule

// ===== rtl/min_square_sum_partition_core.sv =====
// Top level of the minimum square-sum partition core: stream ports, APB register,
// output word register and assertions. Uses msp_pkg, msp_ctrl and msp_datapath.
`timescale 1ns / 1ps

// The core takes a sequence of unsigned values, one word per cycle on the slave
// stream while it is loading, and keeps running prefix sums in an on-chip memory.
// The word with tlast set closes the sequence; words past MAX_LEN are dropped and
// reported in tuser of the result. After the last word the core clears its first
// DP row and then runs min(group_count, n) layers of the partition dynamic
// program, for n kept values, with the divide-and-conquer split search, walking
// an explicit range stack. While a node is scanned, one candidate split is
// evaluated per cycle by a pipeline that reads the prefix memory and the
// previous DP row. The result word (min_cost in tdata, truncated flag in tuser)
// sits in an output register; new values are accepted once it has been loaded
// there. group_count sits at byte address 0 and resets to 1; a value of 0 yields
// an all-ones cost. Write it only while the core is idle.

module min_square_sum_partition_core #(
  parameter int MAX_LEN    = msp_pkg::MaxLenDef,
  parameter int VALUE_BITS = msp_pkg::ValueBitsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [msp_pkg::DataBits-1:0]   s_tdata,   // [15:0] value
  input  logic                           s_tlast,   // last value of the sequence
  // Result stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [msp_pkg::CostBits-1:0]   m_tdata,   // [55:0] min_cost
  output logic                           m_tuser,   // [0] truncated
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msp_pkg::AddrBits-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  msp_pkg::cmd_t  cmd;
  msp_pkg::stat_t stat;

  logic [msp_pkg::GroupBits-1:0] group_count;
  logic [msp_pkg::CostBits-1:0]  res_cost;
  logic                          res_trunc;
  logic                          out_free;
  logic                          reg_sel;

  // Register decode uses the word address only.
  assign reg_sel = paddr[msp_pkg::AddrBits-1] == msp_pkg::RegGroupCount[msp_pkg::AddrBits-1];
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(group_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= msp_pkg::GroupBits'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      group_count <= pwdata[msp_pkg::GroupBits-1:0];
    end
  end

  // The output slot can take a new word when empty or when it drains this cycle.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.deliver) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      m_tdata <= res_cost;
      m_tuser <= res_trunc;
    end
  end

  msp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  msp_datapath #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_value    (s_tdata),
    .group_count (group_count),
    .stat        (stat),
    .res_cost    (res_cost),
    .res_trunc   (res_trunc)
  );

  // A result word must never overwrite one that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> (!m_tvalid || m_tready))
    else $error("result word overwritten");

  // The split pipeline is drained whenever input words are being taken.
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> stat.pipe_empty)
    else $error("evaluation pipeline busy while loading");

  // The range stack is sized so that children are never discarded.
  assert property (@(posedge clk) disable iff (rst)
    cmd.write_node |-> stat.stack_room)
    else $error("range stack overflow");

endmodule
